// ===== rtl/i2r_pkg.sv =====
package i2r_pkg;

    localparam int VALUE_W = 13;
    localparam int CHAR_W  = 8;
    localparam int AMT_W   = 10;

    localparam logic [VALUE_W-1:0] VALUE_LIMIT = 13'd5000;

    localparam logic [CHAR_W-1:0] CH_NONE = 8'h00;
    localparam logic [CHAR_W-1:0] CH_I    = 8'h49;
    localparam logic [CHAR_W-1:0] CH_V    = 8'h56;
    localparam logic [CHAR_W-1:0] CH_X    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_L    = 8'h4C;
    localparam logic [CHAR_W-1:0] CH_C    = 8'h43;
    localparam logic [CHAR_W-1:0] CH_D    = 8'h44;
    localparam logic [CHAR_W-1:0] CH_M    = 8'h4D;

    // controller to datapath
    typedef struct packed {
        logic load;   // take a new value
        logic step;   // produce one result into the output register
    } i2r_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;   // output register empty or draining this cycle
        logic step_last;  // a step now would produce the final result
    } i2r_status_t;

    // one greedy symbol: amount taken off the remainder and its letters
    typedef struct packed {
        logic [AMT_W-1:0]  amount;
        logic [CHAR_W-1:0] first;
        logic [CHAR_W-1:0] second;
        logic              pair;
    } i2r_sym_t;

    function automatic i2r_sym_t pick_symbol(input logic [VALUE_W-1:0] rem);
        i2r_sym_t s;
        s = '{amount: 10'd1, first: CH_I, second: CH_NONE, pair: 1'b0};
        if (rem >= 13'd1000)
            s = '{amount: 10'd1000, first: CH_M, second: CH_NONE, pair: 1'b0};
        else if (rem >= 13'd900)
            s = '{amount: 10'd900, first: CH_C, second: CH_M, pair: 1'b1};
        else if (rem >= 13'd500)
            s = '{amount: 10'd500, first: CH_D, second: CH_NONE, pair: 1'b0};
        else if (rem >= 13'd400)
            s = '{amount: 10'd400, first: CH_C, second: CH_D, pair: 1'b1};
        else if (rem >= 13'd100)
            s = '{amount: 10'd100, first: CH_C, second: CH_NONE, pair: 1'b0};
        else if (rem >= 13'd90)
            s = '{amount: 10'd90, first: CH_X, second: CH_C, pair: 1'b1};
        else if (rem >= 13'd50)
            s = '{amount: 10'd50, first: CH_L, second: CH_NONE, pair: 1'b0};
        else if (rem >= 13'd40)
            s = '{amount: 10'd40, first: CH_X, second: CH_L, pair: 1'b1};
        else if (rem >= 13'd10)
            s = '{amount: 10'd10, first: CH_X, second: CH_NONE, pair: 1'b0};
        else if (rem >= 13'd9)
            s = '{amount: 10'd9, first: CH_I, second: CH_X, pair: 1'b1};
        else if (rem >= 13'd5)
            s = '{amount: 10'd5, first: CH_V, second: CH_NONE, pair: 1'b0};
        else if (rem >= 13'd4)
            s = '{amount: 10'd4, first: CH_I, second: CH_V, pair: 1'b1};
        return s;
    endfunction

endpackage

// ===== rtl/i2r_ctrl.sv =====
module i2r_ctrl
    import i2r_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  i2r_status_t status,
    output i2r_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg;
    logic state_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign cmd.load = s_tvalid && s_tready;
    assign cmd.step = (state_reg == ST_EMIT) && status.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (cmd.step && status.step_last)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/i2r_datapath.sv =====
module i2r_datapath
    import i2r_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  i2r_cmd_t           cmd,
    output i2r_status_t        status,
    input  logic [VALUE_W-1:0] value,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [CHAR_W-1:0]  m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);

    logic [VALUE_W-1:0] rem_reg;
    logic [VALUE_W-1:0] rem_next;
    logic [CHAR_W-1:0]  pend_char_reg;
    logic [CHAR_W-1:0]  pend_char_next;
    logic               pend_valid_reg;
    logic               pend_valid_next;

    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               out_has_reg;
    logic               out_big_reg;
    logic               out_last_reg;

    logic [CHAR_W-1:0]  res_char;
    logic               res_has;
    logic               res_big;
    logic               res_last;

    i2r_sym_t           sym;
    logic [VALUE_W-1:0] rem_sub;

    assign sym     = pick_symbol(rem_reg);
    assign rem_sub = rem_reg - {{(VALUE_W-AMT_W){1'b0}}, sym.amount};

    always_comb
    begin
        res_char        = CH_NONE;
        res_has         = 1'b0;
        res_big         = 1'b0;
        res_last        = 1'b1;
        rem_next        = rem_reg;
        pend_char_next  = pend_char_reg;
        pend_valid_next = pend_valid_reg;
        if (rem_reg > VALUE_LIMIT)
        begin
            res_big = 1'b1;
        end
        else if (pend_valid_reg)
        begin
            // second letter of a subtractive pair
            res_char        = pend_char_reg;
            res_has         = 1'b1;
            res_last        = (rem_reg == '0);
            pend_valid_next = 1'b0;
        end
        else if (rem_reg != '0)
        begin
            res_char = sym.first;
            res_has  = 1'b1;
            rem_next = rem_sub;
            if (sym.pair)
            begin
                res_last        = 1'b0;
                pend_char_next  = sym.second;
                pend_valid_next = 1'b1;
            end
            else
            begin
                res_last = (rem_sub == '0);
            end
        end
        // zero input: the defaults give the empty final beat
    end

    assign status.out_free  = !out_valid_reg || m_tready;
    assign status.step_last = res_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                pend_valid_reg <= 1'b0;
            else if (cmd.step)
                pend_valid_reg <= pend_valid_next;
            if (cmd.step)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            rem_reg <= value;
        else if (cmd.step)
            rem_reg <= rem_next;
        if (cmd.step)
        begin
            pend_char_reg <= pend_char_next;
            out_char_reg  <= res_char;
            out_has_reg   <= res_has;
            out_big_reg   <= res_big;
            out_last_reg  <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = {out_big_reg, out_has_reg};
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_big_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_big_reg) |-> (!out_has_reg && out_last_reg))
        else $error("too_large beat carries a letter or is not final");

    a_pair_pends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && !pend_valid_reg && sym.pair && res_has) |=> pend_valid_reg)
        else $error("subtractive pair did not leave its second letter pending");

    a_pend_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && pend_valid_reg && !cmd.load) |=> !pend_valid_reg)
        else $error("pending letter not cleared after it was sent");

    a_pair_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && pend_valid_next && !pend_valid_reg) |=> !out_last_reg)
        else $error("first letter of a pair marked final");
`endif

endmodule

// ===== rtl/integer_to_roman_numeral.sv =====
// Integer to Roman numeral converter. A 13-bit unsigned value taken on the
// s_ stream is written out on the m_ stream as its Roman numeral, one ASCII
// letter per beat (I V X L C D M), with tlast on the final beat. Thousands
// are repeated M, up to MMMMM for 5000; other digits use the subtractive
// forms IV, IX, XL, XC, CD, CM. Zero gives one empty beat, a value above
// 5000 one beat flagged too_large; neither carries a letter. A value is
// taken and then one beat is produced per cycle while the sink keeps up.
// The letter sequencer greedily takes the largest symbol off the remainder
// and sends one letter a cycle, also only while the sink keeps up (a
// subtractive pair gives two beats, its two letters in turn).
// The next value is accepted as soon as the final beat of the previous one
// sits in the output register.
module integer_to_roman_numeral
    import i2r_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [12:0] value, [15:13] zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] char_code
    output logic [1:0]  m_tuser,   // [0] has_char, [1] too_large
    output logic        m_tlast
);

    i2r_cmd_t    cmd;
    i2r_status_t status;

    i2r_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    i2r_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .value    (s_tdata[VALUE_W-1:0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
